@@ design/fua_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fua_pkg: shared types and constants of the H.264 RTP FU-A packetizer
// Word layouts for the frame and packet channels, parse phases, the result
// group handed from the parser to the output queue, and protocol constants.
// ----------------------------------------------------------------------------
package fua_pkg;

    localparam int LENGTH_BITS = 22;
    // Compare width that holds both a length and a 16-bit payload size plus one.
    localparam int CMP_BITS = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

    localparam int GRP_DEPTH = 3;
    localparam int GRP_CNT_BITS = $clog2(GRP_DEPTH + 1);

    localparam logic [15:0] MAX_PAYLOAD_RESET    = 16'd1400;
    localparam logic [16:0] TIME_INCREMENT_RESET = 17'd3000;
    localparam logic [15:0] MIN_PAYLOAD          = 16'd3;
    localparam logic [15:0] FU_OVERHEAD          = 16'd2;

    localparam logic [7:0] NRI_MASK    = 8'hE0;
    localparam logic [7:0] TYPE_MASK   = 8'h1F;
    localparam logic [7:0] FU_A_TYPE   = 8'd28;
    localparam logic [7:0] FU_START    = 8'h80;
    localparam logic [7:0] FU_END      = 8'h40;
    localparam logic [7:0] SC_ONE      = 8'h01;
    localparam logic [7:0] SC_ZERO     = 8'h00;

    localparam logic [2:0] SC3_USED = 3'd3;
    localparam logic [2:0] SC4_USED = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_MAX_PAYLOAD    = 1'b0;
    localparam logic CFG_TIME_INCREMENT = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_SC0,
        PH_SC1,
        PH_SC2,
        PH_SC3,
        PH_NAL
    } phase_t;

    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   frame_first;
        logic                   frame_last;
        logic [LENGTH_BITS-1:0] frame_length;
        logic [31:0]            frame_time;
    } frame_word_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        packet_start;
        logic        packet_end;
        logic        marker_bit;
        logic [31:0] rtp_time;
        logic        start_code_error;
    } pkt_word_t;

    typedef struct packed {
        pkt_word_t [GRP_DEPTH-1:0] words;
        logic [GRP_CNT_BITS-1:0]   count;
    } pkt_group_t;

    localparam pkt_word_t ERROR_WORD = '{
        out_byte: 8'd0, packet_start: 1'b0, packet_end: 1'b0,
        marker_bit: 1'b0, rtp_time: 32'd0, start_code_error: 1'b1
    };

endpackage

@@ design/fua_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fua_parser: start code check, NAL tracking and FU-A framing
// Holds the frame state and the configuration registers and turns each
// accepted frame byte into a group of zero to three packet words.
// ----------------------------------------------------------------------------
module fua_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [16:0]          cfg_data,
    input  fua_pkg::frame_word_t frame_word,
    input  logic                 frame_fire,
    output fua_pkg::pkt_group_t  group
);
    import fua_pkg::*;

    localparam int LB = LENGTH_BITS;

    logic [15:0]   max_payload_reg;
    logic [16:0]   time_increment_reg;
    phase_t        phase_reg, phase_next;
    logic [LB-1:0] pos_reg, pos_next;
    logic [LB-1:0] nal_len_reg, nal_len_next;
    logic [7:0]    nal_hdr_reg, nal_hdr_next;
    logic          frag_reg, frag_next;
    logic [15:0]   fill_reg, fill_next;
    logic [31:0]   time_reg, time_next;

    logic [15:0]       eff_payload;
    logic [15:0]       frag_size;
    phase_t            phase_cur;
    logic [7:0]        d;
    logic [LB-1:0]     used_len;
    logic [LB-1:0]     calc_len;
    logic [CMP_BITS-1:0] k_plus1;
    logic [CMP_BITS-1:0] len_w;
    logic [CMP_BITS-1:0] fstart;
    logic [CMP_BITS-1:0] remain;
    logic [16:0]       fill_plus1;
    logic              frag_last;
    logic              frag_end;
    logic [7:0]        fu_ind;
    logic [7:0]        fu_hdr;
    pkt_word_t         data_word;

    assign eff_payload = (max_payload_reg < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_reg;
    assign frag_size   = eff_payload - FU_OVERHEAD;
    assign d           = frame_word.data_byte;
    assign phase_cur   = frame_word.frame_first ? PH_SC0 : phase_reg;

    assign used_len = (phase_cur == PH_SC3) ? LB'(SC4_USED) : LB'(SC3_USED);
    assign calc_len = (frame_word.frame_length > used_len)
                    ? frame_word.frame_length - used_len : '0;

    // Fragment bookkeeping: the current fragment began fill_reg bytes ago.
    assign k_plus1    = CMP_BITS'(pos_reg) + CMP_BITS'(1);
    assign len_w      = CMP_BITS'(nal_len_reg);
    assign fstart     = (CMP_BITS'(pos_reg) >= CMP_BITS'(fill_reg))
                      ? CMP_BITS'(pos_reg) - CMP_BITS'(fill_reg) : '0;
    assign remain     = len_w - fstart;
    assign frag_last  = remain <= CMP_BITS'(frag_size);
    assign fill_plus1 = {1'b0, fill_reg} + 17'd1;
    assign frag_end   = (fill_plus1 >= {1'b0, frag_size}) || (k_plus1 == len_w);
    assign fu_ind     = (nal_hdr_reg & NRI_MASK) | FU_A_TYPE;
    assign fu_hdr     = (nal_hdr_reg & TYPE_MASK)
                      | ((pos_reg == LB'(1)) ? FU_START : 8'd0)
                      | (frag_last ? FU_END : 8'd0);

    always_comb
    begin
        data_word              = '0;
        data_word.out_byte     = d;
        data_word.packet_end   = frag_end;
        data_word.marker_bit   = frag_last;
        data_word.rtp_time     = time_reg;
    end

    always_comb
    begin
        phase_next   = phase_cur;
        pos_next     = frame_word.frame_first ? '0 : pos_reg;
        fill_next    = frame_word.frame_first ? '0 : fill_reg;
        nal_len_next = nal_len_reg;
        nal_hdr_next = nal_hdr_reg;
        frag_next    = frag_reg;
        time_next    = time_reg;
        group        = '0;

        unique case (phase_cur)
            PH_WAIT:
            begin
            end
            PH_SC0, PH_SC1:
            begin
                if (d != SC_ZERO)
                begin
                    group.words[0] = ERROR_WORD;
                    group.count    = GRP_CNT_BITS'(1);
                    phase_next     = PH_WAIT;
                end
                else
                begin
                    phase_next = (phase_cur == PH_SC0) ? PH_SC1 : PH_SC2;
                end
            end
            PH_SC2, PH_SC3:
            begin
                if (d == SC_ONE)
                begin
                    time_next    = (frame_word.frame_time != 32'd0) ? frame_word.frame_time
                                 : time_reg + {15'd0, time_increment_reg};
                    nal_len_next = calc_len;
                    pos_next     = '0;
                    fill_next    = '0;
                    frag_next    = CMP_BITS'(calc_len) > CMP_BITS'(eff_payload);
                    phase_next   = (calc_len != '0) ? PH_NAL : PH_WAIT;
                end
                else if (d == SC_ZERO && phase_cur == PH_SC2)
                begin
                    phase_next = PH_SC3;
                end
                else
                begin
                    group.words[0] = ERROR_WORD;
                    group.count    = GRP_CNT_BITS'(1);
                    phase_next     = PH_WAIT;
                end
            end
            PH_NAL:
            begin
                if (!frag_reg)
                begin
                    group.words[0].out_byte     = d;
                    group.words[0].packet_start = (pos_reg == '0);
                    group.words[0].packet_end   = (k_plus1 == len_w);
                    group.words[0].marker_bit   = 1'b1;
                    group.words[0].rtp_time     = time_reg;
                    group.count                 = GRP_CNT_BITS'(1);
                end
                else if (pos_reg == '0)
                begin
                    // The NAL header byte is folded into the FU indicator and header.
                    nal_hdr_next = d;
                end
                else
                begin
                    if (fill_reg == 16'd0)
                    begin
                        group.words[0].out_byte     = fu_ind;
                        group.words[0].packet_start = 1'b1;
                        group.words[0].marker_bit   = frag_last;
                        group.words[0].rtp_time     = time_reg;
                        group.words[1].out_byte     = fu_hdr;
                        group.words[1].marker_bit   = frag_last;
                        group.words[1].rtp_time     = time_reg;
                        group.words[2]              = data_word;
                        group.count                 = GRP_CNT_BITS'(3);
                    end
                    else
                    begin
                        group.words[0] = data_word;
                        group.count    = GRP_CNT_BITS'(1);
                    end
                    fill_next = frag_end ? 16'd0 : fill_plus1[15:0];
                end
                pos_next = k_plus1[LB-1:0];
                if (CMP_BITS'(k_plus1[LB-1:0]) >= len_w)
                begin
                    phase_next = PH_WAIT;
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
            end
        endcase

        if (frame_word.frame_last)
        begin
            // A frame that ends inside its start code still reports one error.
            if ((phase_next == PH_SC0 || phase_next == PH_SC1 || phase_next == PH_SC2 ||
                 phase_next == PH_SC3) && group.count == '0)
            begin
                group.words[0] = ERROR_WORD;
                group.count    = GRP_CNT_BITS'(1);
            end
            phase_next = PH_WAIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg    <= MAX_PAYLOAD_RESET;
            time_increment_reg <= TIME_INCREMENT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_PAYLOAD:    max_payload_reg    <= cfg_data[15:0];
                CFG_TIME_INCREMENT: time_increment_reg <= cfg_data;
                default:            max_payload_reg    <= max_payload_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            pos_reg     <= '0;
            nal_len_reg <= '0;
            nal_hdr_reg <= '0;
            frag_reg    <= 1'b0;
            fill_reg    <= '0;
            time_reg    <= '0;
        end
        else if (frame_fire)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            nal_len_reg <= nal_len_next;
            nal_hdr_reg <= nal_hdr_next;
            frag_reg    <= frag_next;
            fill_reg    <= fill_next;
            time_reg    <= time_next;
        end
    end

endmodule

@@ design/fua_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fua_outq: result group buffer and packet output register
// Holds the words of one frame byte and hands them out one per cycle, unless
// pkt_ready stalls them, through an output register that decouples the packet channel.
// ----------------------------------------------------------------------------
module fua_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  fua_pkg::pkt_group_t group,
    input  logic                frame_fire,
    output logic                load_ready,
    output logic                pkt_valid,
    input  logic                pkt_ready,
    output fua_pkg::pkt_word_t  pkt_word
);
    import fua_pkg::*;

    pkt_word_t [GRP_DEPTH-1:0] grp_reg;
    logic [GRP_CNT_BITS-1:0]   cnt_reg;
    logic                      valid_reg;
    pkt_word_t                 word_reg;
    logic                      out_load;

    assign out_load   = (cnt_reg != '0) && (!valid_reg || pkt_ready);
    // A new group may enter when the buffer is empty or its last buffered word moves out this cycle.
    assign load_ready = (cnt_reg == '0) || (cnt_reg == GRP_CNT_BITS'(1) && out_load);
    assign pkt_valid  = valid_reg;
    assign pkt_word   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (frame_fire)
        begin
            cnt_reg <= group.count;
        end
        else if (out_load)
        begin
            cnt_reg <= cnt_reg - GRP_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_fire)
        begin
            grp_reg <= group.words;
        end
        else if (out_load)
        begin
            for (int i = 0; i < GRP_DEPTH - 1; i++)
            begin
                grp_reg[i] <= grp_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (pkt_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            word_reg <= grp_reg[0];
        end
    end

endmodule

@@ design/h264_rtp_fua_packetizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer: H.264 frame to RTP payload words, FU-A mode
// Checks and strips the start code, stamps the frame time and splits long
// NAL units into FU-A fragments with indicator and header bytes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | word
//  ---------+-----------+--------------------------+---------------------
//  frame    | in        | frame_valid/frame_ready  | frame_word_t, 1 byte
//  packet   | out       | pkt_valid/pkt_ready      | pkt_word_t, 1 byte
//  config   | in        | cfg_we                   | cfg_index, cfg_data
//
// One frame byte is taken per cycle while frame_ready is high; a byte yields
// 0, 1 or 3 words and the output register moves one word per cycle when not
// stalled, so the byte that opens a fragment holds the frame channel until its words move out.
// A word passes through the group buffer and then the output register before it is offered.
// Reset clears all frame state at once; there is no clearing pass.
// A stall on the packet channel backs up into frame_ready once a group waits behind the output register.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [16:0]          cfg_data,
    input  logic                 frame_valid,
    output logic                 frame_ready,
    input  fua_pkg::frame_word_t frame_word,
    output logic                 pkt_valid,
    input  logic                 pkt_ready,
    output fua_pkg::pkt_word_t   pkt_word
);
    import fua_pkg::*;

    pkt_group_t group;
    logic       frame_fire;

    assign frame_fire = frame_valid && frame_ready;

    fua_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame_word (frame_word),
        .frame_fire (frame_fire),
        .group      (group)
    );

    fua_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .group      (group),
        .frame_fire (frame_fire),
        .load_ready (frame_ready),
        .pkt_valid  (pkt_valid),
        .pkt_ready  (pkt_ready),
        .pkt_word   (pkt_word)
    );

endmodule

@@ design/fua_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fua_checker: port-level checks of the FU-A packetizer
// Watches the packet channel for word holding, error word layout and
// behavior around reset.
// ----------------------------------------------------------------------------
module fua_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 frame_valid,
    input logic                 frame_ready,
    input logic                 pkt_valid,
    input logic                 pkt_ready,
    input fua_pkg::pkt_word_t   pkt_word
);
    import fua_pkg::*;

    // A stalled word stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(pkt_word))
        else $error("packet word changed while stalled");

    // An error word carries nothing but its flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_word.start_code_error |->
            pkt_word.out_byte == 8'd0 && !pkt_word.packet_start &&
            !pkt_word.packet_end && !pkt_word.marker_bit && pkt_word.rtp_time == 32'd0)
        else $error("error word with payload fields set");

    // A clock edge seen in reset leaves the packet channel idle.
    assert property (@(posedge clk) !rst_n |=> !pkt_valid)
        else $error("packet word valid during reset");

    // A rising packet word follows a taken byte through the group buffer and output register, or an earlier word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pkt_valid) |-> $past(frame_valid && frame_ready, 2) || $past(pkt_valid))
        else $error("packet word without a preceding frame byte");

endmodule

bind h264_rtp_fua_packetizer fua_checker u_fua_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .pkt_valid   (pkt_valid),
    .pkt_ready   (pkt_ready),
    .pkt_word    (pkt_word)
);
